// ===== sv/pbu_pkg.sv =====
// ----------------------------------------------------------------------------
// pbu_pkg: shared types and constants for the PowerPC branch unit
// Holds the instruction patterns, opcode and SPR numbers, and the structs
// that carry results and register updates between the unit's modules.
// ----------------------------------------------------------------------------
package pbu_pkg;

  // Instruction patterns as the architecture encodes them.
  localparam logic [31:0] PAT_B     = 32'h4800_0000;
  localparam logic [31:0] PAT_BC    = 32'h4000_0000;
  localparam logic [31:0] PAT_BCCTR = 32'h4C00_0420;
  localparam logic [31:0] PAT_BCLR  = 32'h4C00_0020;
  localparam logic [31:0] PAT_MFSPR = 32'h7C00_02A6;
  localparam logic [31:0] PAT_MTSPR = 32'h7C00_03A6;
  localparam logic [4:0]  FIVE_BITS = 5'h1F;

  // Primary opcodes (word bits 31:26) and extended opcodes (word bits 10:1).
  localparam logic [5:0] OP_B     = PAT_B[31:26];
  localparam logic [5:0] OP_BC    = PAT_BC[31:26];
  localparam logic [5:0] OP_XL    = PAT_BCLR[31:26];
  localparam logic [5:0] OP_X     = PAT_MFSPR[31:26];
  localparam logic [9:0] XO_BCLR  = PAT_BCLR[10:1];
  localparam logic [9:0] XO_BCCTR = PAT_BCCTR[10:1];
  localparam logic [9:0] XO_MFSPR = PAT_MFSPR[10:1];
  localparam logic [9:0] XO_MTSPR = PAT_MTSPR[10:1];

  // Special register numbers after the half swap of the SPR field.
  localparam logic [9:0] SPR_XER = 10'd1;
  localparam logic [9:0] SPR_LR  = 10'd8;
  localparam logic [9:0] SPR_CTR = 10'd9;

  // One result beat.
  typedef struct packed {
    logic [31:0] next_addr;
    logic        taken;
    logic [63:0] dest_value;
    logic        dest_valid;
    logic        illegal;
  } pbu_result_t;

  // Current contents of the special registers.
  typedef struct packed {
    logic [63:0] lr;
    logic [63:0] ctr;
    logic [31:0] xer;
  } pbu_state_t;

  // Write requests to the special registers.
  typedef struct packed {
    logic        lr_we;
    logic [63:0] lr_data;
    logic        ctr_we;
    logic [63:0] ctr_data;
    logic        xer_we;
    logic [31:0] xer_data;
  } pbu_update_t;

endpackage

// ===== sv/pbu_in_if.sv =====
// ----------------------------------------------------------------------------
// pbu_in_if: instruction channel of the branch unit
// Carries one instruction with its address, the condition register and a
// general register value per beat.
// ----------------------------------------------------------------------------
interface pbu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] instr_addr;
  logic [31:0] cond_reg;
  logic [63:0] source_value;

  modport source (output valid, output instr_word, output instr_addr,
                  output cond_reg, output source_value, input ready);
  modport sink   (input valid, input instr_word, input instr_addr,
                  input cond_reg, input source_value, output ready);
endinterface

// ===== sv/pbu_out_if.sv =====
// ----------------------------------------------------------------------------
// pbu_out_if: result channel of the branch unit
// Carries the next address, branch outcome and SPR read data per beat.
// ----------------------------------------------------------------------------
interface pbu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_addr;
  logic        taken;
  logic [63:0] dest_value;
  logic        dest_valid;
  logic        illegal;

  modport source (output valid, output next_addr, output taken,
                  output dest_value, output dest_valid, output illegal,
                  input ready);
  modport sink   (input valid, input next_addr, input taken,
                  input dest_value, input dest_valid, input illegal,
                  output ready);
endinterface

// ===== sv/pbu_sprs.sv =====
// ----------------------------------------------------------------------------
// pbu_sprs: link, count and fixed-point exception registers
// Holds LR, CTR and XER and applies the write requests of an executing
// instruction when that instruction commits.
// ----------------------------------------------------------------------------
module pbu_sprs
  import pbu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  pbu_update_t upd,
  output pbu_state_t  state
);

  logic [63:0] lr;
  logic [63:0] ctr;
  logic [31:0] xer;

  // Register writes take effect only for a committing instruction.
  always_ff @(posedge clk) begin
    if (rst) begin
      lr  <= '0;
      ctr <= '0;
      xer <= '0;
    end else if (commit) begin
      if (upd.lr_we) begin
        lr <= upd.lr_data;
      end
      if (upd.ctr_we) begin
        ctr <= upd.ctr_data;
      end
      if (upd.xer_we) begin
        xer <= upd.xer_data;
      end
    end
  end

  assign state.lr  = lr;
  assign state.ctr = ctr;
  assign state.xer = xer;

endmodule

// ===== sv/pbu_exec.sv =====
// ----------------------------------------------------------------------------
// pbu_exec: decode and execute of one instruction
// Decodes b, bc, bclr, bcctr, mfspr and mtspr, evaluates the count and
// condition tests, forms the next address and the register updates.
// ----------------------------------------------------------------------------
module pbu_exec
  import pbu_pkg::*;
(
  input  logic [31:0] instr_word,
  input  logic [31:0] instr_addr,
  input  logic [31:0] cond_reg,
  input  logic [63:0] source_value,
  input  pbu_state_t  state,
  output pbu_result_t res,
  output pbu_update_t upd
);

  logic [5:0]  op;
  logic [9:0]  xo;
  logic [4:0]  bo;
  logic [4:0]  bi;
  logic        aa;
  logic        lk;
  logic [9:0]  spr;
  logic [31:0] seq_addr;
  logic [31:0] disp_b;
  logic [31:0] disp_bc;
  logic [31:0] rel_b;
  logic [31:0] rel_bc;
  logic [63:0] ctr_dec;
  logic        ctr_ok;
  logic        cond_ok;

  // Field extraction; bit 0 of the architecture is the word's MSB.
  assign op  = instr_word[31:26];
  assign xo  = instr_word[10:1];
  assign bo  = instr_word[25:21] & FIVE_BITS;
  assign bi  = instr_word[20:16];
  assign aa  = instr_word[1];
  assign lk  = instr_word[0];
  assign spr = {instr_word[15:11], instr_word[20:16]};

  // Sequential address and the two sign-extended displacements.
  assign seq_addr = instr_addr + 32'd4;
  assign disp_b   = {{6{instr_word[25]}}, instr_word[25:2], 2'b00};
  assign disp_bc  = {{16{instr_word[15]}}, instr_word[15:2], 2'b00};
  assign rel_b    = instr_addr + disp_b;
  assign rel_bc   = instr_addr + disp_bc;

  // Count test on the decremented value and condition register bit test.
  assign ctr_dec = state.ctr - 64'd1;
  assign ctr_ok  = bo[2] | (bo[1] ? (ctr_dec == '0) : (ctr_dec != '0));
  assign cond_ok = bo[4] | (cond_reg[~bi] == bo[3]);

  // Result and register updates per instruction class.
  always_comb begin
    res.next_addr  = seq_addr;
    res.taken      = 1'b0;
    res.dest_value = '0;
    res.dest_valid = 1'b0;
    res.illegal    = 1'b0;
    upd.lr_we      = 1'b0;
    upd.lr_data    = {32'd0, seq_addr};
    upd.ctr_we     = 1'b0;
    upd.ctr_data   = ctr_dec;
    upd.xer_we     = 1'b0;
    upd.xer_data   = source_value[31:0];
    case (op)
      OP_B: begin
        res.next_addr = aa ? disp_b : rel_b;
        res.taken     = 1'b1;
        upd.lr_we     = lk;
      end
      OP_BC: begin
        upd.ctr_we = ~bo[2];
        upd.lr_we  = lk;
        if (ctr_ok && cond_ok) begin
          res.next_addr = aa ? disp_bc : rel_bc;
          res.taken     = 1'b1;
        end
      end
      OP_XL: begin
        if (xo == XO_BCLR) begin
          // The target comes from the link value before this update.
          upd.ctr_we = ~bo[2];
          upd.lr_we  = lk;
          if (ctr_ok && cond_ok) begin
            res.next_addr = {state.lr[31:2], 2'b00};
            res.taken     = 1'b1;
          end
        end else if (xo == XO_BCCTR) begin
          // The decrementing form is invalid here: the count is left alone.
          upd.lr_we = lk;
          if (cond_ok) begin
            res.next_addr = {state.ctr[31:2], 2'b00};
            res.taken     = 1'b1;
          end
        end else begin
          res.illegal = 1'b1;
        end
      end
      OP_X: begin
        if (xo == XO_MFSPR || xo == XO_MTSPR) begin
          case (spr)
            SPR_XER: begin
              res.dest_value = {32'd0, state.xer};
              upd.xer_we     = (xo == XO_MTSPR);
            end
            SPR_LR: begin
              res.dest_value = state.lr;
              upd.lr_we      = (xo == XO_MTSPR);
              upd.lr_data    = source_value;
            end
            SPR_CTR: begin
              res.dest_value = state.ctr;
              upd.ctr_we     = (xo == XO_MTSPR);
              upd.ctr_data   = source_value;
            end
            default: begin
              res.illegal = 1'b1;
            end
          endcase
          if (res.illegal || xo == XO_MTSPR) begin
            res.dest_value = '0;
          end else begin
            res.dest_valid = 1'b1;
          end
        end else begin
          res.illegal = 1'b1;
        end
      end
      default: begin
        res.illegal = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/powerpc_branch_unit.sv =====
// Pipeline: a beat accepted into the input register executes from there and
//   enters the result register when that register is free to take it.
// Throughput: one instruction per cycle unless result.ready stalls; the
//   SPRs update in the same cycle an instruction enters the result register.
// Reset: synchronous rst clears both valid flags and zeroes LR, CTR and XER.
// ----------------------------------------------------------------------------
// powerpc_branch_unit: branch processing unit top level
// Input register, single-pass decode and execute against the special
// registers, and a result register on the output channel.
// ----------------------------------------------------------------------------
module powerpc_branch_unit
  import pbu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  pbu_in_if.sink    instr,
  pbu_out_if.source result
);

  logic        s1_valid;
  logic [31:0] s1_word;
  logic [31:0] s1_addr;
  logic [31:0] s1_cr;
  logic [63:0] s1_src;
  logic        out_valid;
  pbu_result_t out_res;
  logic        out_free;
  logic        advance;
  pbu_result_t exec_res;
  pbu_update_t exec_upd;
  pbu_state_t  spr_state;

  // Handshake: the result register frees when empty or being taken.
  assign out_free    = ~out_valid | result.ready;
  assign advance     = s1_valid & out_free;
  assign instr.ready = ~s1_valid | out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (instr.ready) begin
      s1_valid <= instr.valid;
    end
    if (instr.ready && instr.valid) begin
      s1_word <= instr.instr_word;
      s1_addr <= instr.instr_addr;
      s1_cr   <= instr.cond_reg;
      s1_src  <= instr.source_value;
    end
  end

  pbu_exec u_exec (
    .instr_word   (s1_word),
    .instr_addr   (s1_addr),
    .cond_reg     (s1_cr),
    .source_value (s1_src),
    .state        (spr_state),
    .res          (exec_res),
    .upd          (exec_upd)
  );

  pbu_sprs u_sprs (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .upd    (exec_upd),
    .state  (spr_state)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_res <= exec_res;
    end
  end

  assign result.valid      = out_valid;
  assign result.next_addr  = out_res.next_addr;
  assign result.taken      = out_res.taken;
  assign result.dest_value = out_res.dest_value;
  assign result.dest_valid = out_res.dest_valid;
  assign result.illegal    = out_res.illegal;

`ifndef SYNTHESIS
  // An illegal instruction neither branches nor returns register data.
  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.illegal) |->
      (!out_res.taken && !out_res.dest_valid && out_res.dest_value == '0))
    else $error("illegal result carries branch or register data");

  // A register read is never a taken branch.
  a_read_not_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.dest_valid) |-> !out_res.taken)
    else $error("mfspr result marked as taken");

  // An instruction that leaves the input register shows up as a result.
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("executed instruction lost before the result register");
`endif

endmodule
